/* hw/rtl/pba_pkg.sv */
package pba_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] reg_index_t;

    localparam op_t OP_ALLOC   = 2'd0;
    localparam op_t OP_FREE    = 2'd1;
    localparam op_t OP_RELEASE = 2'd2;

    localparam reg_index_t REG_TOTAL    = 2'd0;
    localparam reg_index_t REG_RESERVED = 2'd1;

    localparam int          WORD_W   = 32;
    localparam int          CNT_W    = 16;
    localparam int          RES_W    = 27;
    localparam logic [31:0] ALL_USED = 32'hFFFF_FFFF;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  count_t;

    function automatic logic [4:0] first_one(input word_t w);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [4:0] first_zero(input word_t w);
        logic [4:0] pos;
        pos = 5'd31;
        for (int i = WORD_W - 2; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* hw/rtl/page_bitmap_allocator.sv */
// Channel   Direction  Handshake              Payload
// command   in         start, busy            operation, page_address
// result    out        done (one-cycle word)  result_address, ok, used_pages
// config    in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// One command at a time; unknown codes, rejected frees and releases and an
// allocate with no free page finish in the dispatch state, a free or release
// that reads the maps finishes in the map-read state, and allocate passes
// through the dispatch, row and word states (two dependent reads of the
// summary-row RAM and the page-map RAM, then one write-back).
// A new command is taken in the cycle done is high.
// Reset clears the per-row summary flags, so both RAMs need no clearing pass.
// The receiver cannot stall; results are never held.
module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       operation,
    input  logic [31:0]      page_address,
    output logic             done,
    output logic [RES_W-1:0] result_address,
    output logic             ok,
    output logic [CNT_W-1:0] used_pages,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
    localparam int ROWS      = (MAP_WORDS + 31) / 32;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [31:0] MAX_P = 32'(MAX_PAGES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_AROW  = 3'd2;
    localparam logic [2:0] S_AWORD = 3'd3;
    localparam logic [2:0] S_FREAD = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic             done_reg, done_next;
    logic [ROWS-1:0]  summary_reg, summary_next;
    count_t           free_count_reg, free_count_next;
    count_t           total_reg, reserved_reg;
    op_t              op_reg, op_next;
    logic [31:0]      addr_reg, addr_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [4:0]       col_reg, col_next;
    logic [4:0]       bit_reg, bit_next;
    word_t            row_data_reg, row_data_next;
    logic [RES_W-1:0] res_addr_reg, res_addr_next;
    logic             ok_reg, ok_next;
    count_t           used_reg, used_next;

    logic               pm_we;
    logic [WORD_AW-1:0] pm_waddr, pm_raddr;
    word_t              pm_wdata, pm_rdata;
    logic               rm_we;
    logic [ROW_W-1:0]   rm_waddr, rm_raddr;
    word_t              rm_wdata, rm_rdata;

    count_t           eff_total;
    logic [ROW_W-1:0] sum_first;
    logic [31:0]      idx32, w32, page32;
    logic [63:0]      addr64;
    logic [4:0]       col_first, zero_pos;
    logic             clr_ok, finish;
    word_t            row_eff, word_eff, new_word, new_row;

    pba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_page_map (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    pba_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_free_rows (
        .clk   (clk),
        .we    (rm_we),
        .waddr (rm_waddr),
        .wdata (rm_wdata),
        .raddr (rm_raddr),
        .rdata (rm_rdata)
    );

    assign eff_total = (32'(total_reg) > MAX_P) ? MAX_P[CNT_W-1:0] : total_reg;

    always_comb
    begin
        sum_first = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (summary_reg[i])
            begin
                sum_first = ROW_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        summary_next    = summary_reg;
        free_count_next = free_count_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        bit_next        = bit_reg;
        row_data_next   = row_data_reg;
        res_addr_next   = res_addr_reg;
        ok_next         = ok_reg;
        used_next       = used_reg;
        pm_we           = 1'b0;
        pm_waddr        = '0;
        pm_wdata        = '0;
        pm_raddr        = '0;
        rm_we           = 1'b0;
        rm_waddr        = '0;
        rm_wdata        = '0;
        rm_raddr        = '0;
        finish          = 1'b0;
        clr_ok          = 1'b0;

        idx32     = addr_reg >> PAGE_SHIFT;
        col_first = first_one(rm_rdata);
        zero_pos  = first_zero(pm_rdata);
        w32       = (32'(row_reg) << 5) | 32'(col_reg);
        page32    = (w32 << 5) | 32'(zero_pos);
        addr64    = 64'(page32) << PAGE_SHIFT;
        new_word  = pm_rdata | (32'd1 << zero_pos);
        new_row   = row_data_reg & ~(32'd1 << col_reg);
        row_eff   = summary_reg[row_reg] ? rm_rdata : '0;
        word_eff  = row_eff[col_reg] ? pm_rdata : ALL_USED;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    addr_next  = page_address;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                res_addr_next = '0;
                ok_next       = 1'b0;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (summary_reg == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            row_next   = sum_first;
                            rm_raddr   = sum_first;
                            state_next = S_AROW;
                        end
                    end
                    OP_FREE:
                    begin
                        clr_ok = (addr_reg != 32'd0) && (idx32 < 32'(eff_total));
                    end
                    OP_RELEASE:
                    begin
                        clr_ok = (idx32 >= 32'(reserved_reg)) && (idx32 < 32'(eff_total));
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
                if (op_reg == OP_FREE || op_reg == OP_RELEASE)
                begin
                    if (clr_ok)
                    begin
                        row_next   = ROW_W'(idx32 >> 10);
                        col_next   = idx32[9:5];
                        bit_next   = idx32[4:0];
                        rm_raddr   = ROW_W'(idx32 >> 10);
                        pm_raddr   = WORD_AW'(idx32 >> 5);
                        state_next = S_FREAD;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            S_AROW:
            begin
                row_data_next = rm_rdata;
                col_next      = col_first;
                pm_raddr      = WORD_AW'((32'(row_reg) << 5) | 32'(col_first));
                state_next    = S_AWORD;
            end
            S_AWORD:
            begin
                finish = 1'b1;
                if (page32 < 32'(eff_total))
                begin
                    pm_we    = 1'b1;
                    pm_waddr = WORD_AW'(w32);
                    pm_wdata = new_word;
                    if (new_word == ALL_USED)
                    begin
                        rm_we    = 1'b1;
                        rm_waddr = row_reg;
                        rm_wdata = new_row;
                        if (new_row == '0)
                        begin
                            summary_next[row_reg] = 1'b0;
                        end
                    end
                    free_count_next = free_count_reg - count_t'(1);
                    ok_next         = 1'b1;
                    res_addr_next   = addr64[RES_W-1:0];
                end
            end
            S_FREAD:
            begin
                finish = 1'b1;
                if (word_eff[bit_reg])
                begin
                    pm_we    = 1'b1;
                    pm_waddr = WORD_AW'((32'(row_reg) << 5) | 32'(col_reg));
                    pm_wdata = word_eff & ~(32'd1 << bit_reg);
                    rm_we    = 1'b1;
                    rm_waddr = row_reg;
                    rm_wdata = row_eff | (32'd1 << col_reg);
                    summary_next[row_reg] = 1'b1;
                    free_count_next = free_count_reg + count_t'(1);
                    ok_next         = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            used_next  = (eff_total > free_count_next) ? (eff_total - free_count_next) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            summary_reg    <= '0;
            free_count_reg <= '0;
            total_reg      <= '0;
            reserved_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            summary_reg    <= summary_next;
            free_count_reg <= free_count_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TOTAL)
                begin
                    total_reg <= cfg_data;
                end
                else if (cfg_index == REG_RESERVED)
                begin
                    reserved_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        bit_reg      <= bit_next;
        row_data_reg <= row_data_next;
        res_addr_reg <= res_addr_next;
        ok_reg       <= ok_next;
        used_reg     <= used_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign result_address = res_addr_reg;
    assign ok             = ok_reg;
    assign used_pages     = used_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command accepted without going busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy || $past(busy))
        else $error("done without a command in flight");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> result_address == '0)
        else $error("nonzero address on a failed word");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> used_pages <= eff_total)
        else $error("used count above managed pages");
`endif

endmodule

/* hw/rtl/pba_ram.sv */
module pba_ram
    import pba_pkg::*;
#(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
